FILE: src/jbl_pkg.sv
// Package: types, constants and lookup functions for the JSON byte lexer.
`timescale 1ns / 1ps

package jbl_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int OUT_LINE_W    = 16;

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_PW + 1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_POINT = 8'h2e;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_LBRC  = 8'h7b;
    localparam logic [7:0] CH_RBRC  = 8'h7d;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_RBRK  = 8'h5d;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_COLON = 8'h3a;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STR,
        MODE_ESC
    } t_mode;

    typedef enum logic [2:0] {
        PH_START,
        PH_MINUS,
        PH_ZERO,
        PH_BODY,
        PH_EXP,
        PH_NONNUM
    } t_phase;

    typedef enum logic [3:0] {
        K_LBRACE,
        K_RBRACE,
        K_LBRACKET,
        K_RBRACKET,
        K_COMMA,
        K_COLON,
        K_STR_CHAR,
        K_STR_END,
        K_WORD_CHAR,
        K_NUMBER,
        K_BOOLEAN,
        K_NULL,
        K_BAD_STR,
        K_BAD_WORD
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              ch;
        logic [OUT_LINE_W-1:0]   line;
        logic                    last;
    } t_tok;

    typedef struct packed {
        logic [1:0] cnt;
        t_tok       e0;
        t_tok       e1;
    } t_push;

    // literal letters: sel 0 null, 1 true, 2 false; bit 8 marks a valid position
    function automatic logic [8:0] f_lit(input logic [1:0] sel, input logic [2:0] pos);
        logic [8:0] r;
        begin
            case ({sel, pos})
                5'b00_000: r = {1'b1, 8'h6e};
                5'b00_001: r = {1'b1, 8'h75};
                5'b00_010: r = {1'b1, 8'h6c};
                5'b00_011: r = {1'b1, 8'h6c};
                5'b01_000: r = {1'b1, 8'h74};
                5'b01_001: r = {1'b1, 8'h72};
                5'b01_010: r = {1'b1, 8'h75};
                5'b01_011: r = {1'b1, 8'h65};
                5'b10_000: r = {1'b1, 8'h66};
                5'b10_001: r = {1'b1, 8'h61};
                5'b10_010: r = {1'b1, 8'h6c};
                5'b10_011: r = {1'b1, 8'h73};
                5'b10_100: r = {1'b1, 8'h65};
                default:   r = 9'h000;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: src/jbl_if.sv
// Interfaces: byte input channel and token result channel.
`timescale 1ns / 1ps

interface jbl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface jbl_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [7:0]  char_value;
    logic [15:0] line_number;
    logic        last_of_run;

    modport source (output valid, output kind, output char_value, output line_number,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input char_value, input line_number,
                    input last_of_run, output ready);
endinterface

FILE: src/jbl_lex.sv
// Lexer state and per-byte token decode, up to two tokens per byte.
`timescale 1ns / 1ps

module jbl_lex
    import jbl_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output t_push      o_push
);

    t_mode                r_mode,  n_mode;
    logic [LINE_BITS-1:0] r_line,  n_line;
    t_phase               r_ph,    n_ph;
    logic                 r_ok,    n_ok;
    logic                 r_pt,    n_pt;
    logic                 r_ex,    n_ex;
    logic [2:0]           r_len,   n_len;
    logic [2:0]           r_match, n_match;

    logic [31:0]           line_ext;
    logic [OUT_LINE_W-1:0] line_out;

    assign line_ext = 32'(r_line);
    assign line_out = (line_ext > 32'h0000_ffff) ? {OUT_LINE_W{1'b1}}
                                                 : line_ext[OUT_LINE_W-1:0];

    always_comb begin
        logic [7:0]  c;
        logic        is_punct;
        logic        ws;
        logic        ends;
        t_kind       pk;
        t_kind       wk;
        logic [1:0]  cnt;
        t_tok        toks [2];
        t_phase      b_ph;
        logic        b_ok, b_pt, b_ex;
        logic [2:0]  b_len, b_match;
        logic [8:0]  lc;
        logic        is_dig;

        c        = i_byte;
        cnt      = 2'd0;
        lc       = 9'h000;
        toks[0]  = '{kind: K_LBRACE, ch: 8'h00, line: line_out, last: 1'b0};
        toks[1]  = '{kind: K_LBRACE, ch: 8'h00, line: line_out, last: 1'b0};
        n_mode   = r_mode;
        n_ph     = r_ph;
        n_ok     = r_ok;
        n_pt     = r_pt;
        n_ex     = r_ex;
        n_len    = r_len;
        n_match  = r_match;
        is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);

        is_punct = 1'b1;
        pk       = K_LBRACE;
        case (c)
            CH_LBRC:  pk = K_LBRACE;
            CH_RBRC:  pk = K_RBRACE;
            CH_LBRK:  pk = K_LBRACKET;
            CH_RBRK:  pk = K_RBRACKET;
            CH_COMMA: pk = K_COMMA;
            CH_COLON: pk = K_COLON;
            default:  is_punct = 1'b0;
        endcase
        ws   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        ends = is_punct || ws || (c == CH_QUOTE);

        // classification of the word held in the registers
        if (r_ph != PH_NONNUM) begin
            if (r_ok && r_ph != PH_MINUS && r_ph != PH_EXP && r_ph != PH_START) begin
                wk = K_NUMBER;
            end else begin
                wk = K_BAD_WORD;
            end
        end else if (r_len == 3'd4 && r_match[0]) begin
            wk = K_NULL;
        end else if (r_len == 3'd4 && r_match[1]) begin
            wk = K_BOOLEAN;
        end else if (r_len == 3'd5 && r_match[2]) begin
            wk = K_BOOLEAN;
        end else begin
            wk = K_BAD_WORD;
        end

        // word state the next word byte builds on: fresh unless a word is open
        if (r_mode == MODE_WORD) begin
            b_ph = r_ph;  b_ok = r_ok;  b_pt = r_pt;  b_ex = r_ex;
            b_len = r_len;  b_match = r_match;
        end else begin
            b_ph = PH_START;  b_ok = 1'b1;  b_pt = 1'b0;  b_ex = 1'b0;
            b_len = 3'd0;  b_match = 3'b111;
        end

        unique case (r_mode)
            MODE_STR: begin
                if (c == CH_QUOTE) begin
                    toks[0].kind = K_STR_END;
                    cnt    = 2'd1;
                    n_mode = MODE_IDLE;
                end else if (c == CH_BSL) begin
                    n_mode = MODE_ESC;
                end else if (c < CH_SPACE) begin
                    toks[0].kind = K_BAD_STR;
                    cnt    = 2'd1;
                    n_mode = MODE_IDLE;
                end else begin
                    toks[0].kind = K_STR_CHAR;
                    toks[0].ch   = c;
                    cnt          = 2'd1;
                end
            end
            MODE_ESC: begin
                case (c) inside
                    8'h62, 8'h66, 8'h6e, 8'h72, 8'h74, CH_QUOTE, 8'h2f, CH_BSL: begin
                        toks[0].kind = K_STR_CHAR;
                        toks[0].ch   = c;
                        cnt          = 2'd1;
                        n_mode       = MODE_STR;
                    end
                    CH_LO_U: begin
                        toks[0].kind = K_STR_CHAR;
                        toks[0].ch   = CH_BSL;
                        toks[1].kind = K_STR_CHAR;
                        toks[1].ch   = CH_LO_U;
                        cnt          = 2'd2;
                        n_mode       = MODE_STR;
                    end
                    default: begin
                        toks[0].kind = K_BAD_STR;
                        cnt          = 2'd1;
                        n_mode       = MODE_IDLE;
                    end
                endcase
            end
            MODE_IDLE, MODE_WORD: begin
                if (r_mode == MODE_WORD && ends) begin
                    toks[0].kind = wk;
                    cnt      = 2'd1;
                    n_mode   = MODE_IDLE;
                    n_ph     = PH_START;
                    n_ok     = 1'b1;
                    n_pt     = 1'b0;
                    n_ex     = 1'b0;
                    n_len    = 3'd0;
                    n_match  = 3'b111;
                end
                if (is_punct) begin
                    toks[cnt[0]].kind = pk;
                    cnt = cnt + 2'd1;
                end else if (c == CH_QUOTE) begin
                    n_mode = MODE_STR;
                end else if (!ws) begin
                    n_mode  = MODE_WORD;
                    n_match = b_match;
                    for (int i = 0; i < 3; i++) begin
                        lc = f_lit(2'(i), b_len);
                        if (!(lc[8] && lc[7:0] == c)) begin
                            n_match[i] = 1'b0;
                        end
                    end
                    n_len = (b_len < 3'd6) ? b_len + 3'd1 : b_len;
                    n_ph  = b_ph;
                    n_ok  = b_ok;
                    n_pt  = b_pt;
                    n_ex  = b_ex;
                    case (b_ph)
                        PH_START, PH_MINUS: begin
                            if (c >= CH_ONE && c <= CH_NINE) begin
                                n_ph = PH_BODY;
                            end else if (c == CH_ZERO) begin
                                n_ph = PH_ZERO;
                            end else if (c == CH_MINUS && b_ph == PH_START) begin
                                n_ph = PH_MINUS;
                            end else if (b_ph == PH_START) begin
                                n_ph = PH_NONNUM;
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                        PH_ZERO: begin
                            if (c == CH_POINT) begin
                                n_pt = 1'b1;
                                n_ph = PH_BODY;
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                        PH_BODY: begin
                            if (c == CH_LO_E || c == CH_UP_E) begin
                                if (b_ex) begin
                                    n_ok = 1'b0;
                                end else begin
                                    n_ex = 1'b1;
                                    n_ph = PH_EXP;
                                end
                            end else if (c == CH_POINT) begin
                                if (b_pt) begin
                                    n_ok = 1'b0;
                                end else begin
                                    n_pt = 1'b1;
                                end
                            end else if (!is_dig) begin
                                n_ok = 1'b0;
                            end
                        end
                        PH_EXP: begin
                            if (c == CH_PLUS || c == CH_MINUS || is_dig) begin
                                n_ph = PH_BODY;
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                    toks[cnt[0]].kind = K_WORD_CHAR;
                    toks[cnt[0]].ch   = c;
                    cnt = cnt + 2'd1;
                end
            end
        endcase

        toks[0].last = (cnt == 2'd1);
        toks[1].last = (cnt == 2'd2);

        n_line = (c == CH_LF && r_line != {LINE_BITS{1'b1}}) ? r_line + LINE_BITS'(1)
                                                              : r_line;

        o_push.cnt = i_en ? cnt : 2'd0;
        o_push.e0  = toks[0];
        o_push.e1  = toks[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_line  <= LINE_BITS'(1);
            r_ph    <= PH_START;
            r_ok    <= 1'b1;
            r_pt    <= 1'b0;
            r_ex    <= 1'b0;
            r_len   <= 3'd0;
            r_match <= 3'b111;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_ph    <= n_ph;
            r_ok    <= n_ok;
            r_pt    <= n_pt;
            r_ex    <= n_ex;
            r_len   <= n_len;
            r_match <= n_match;
        end
    end

endmodule

FILE: src/jbl_res_q.sv
// Result queue: takes up to two tokens a cycle, hands out one a cycle while the sink is ready.
`timescale 1ns / 1ps

module jbl_res_q
    import jbl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_push        i_push,
    output logic         o_room,
    jbl_tok_if.source    o_tok
);

    t_tok             r_mem [Q_DEPTH];
    logic [Q_PW-1:0]  r_wr, n_wr;
    logic [Q_PW-1:0]  r_rd, n_rd;
    logic [Q_CW-1:0]  r_cnt, n_cnt;
    logic             pop;
    logic [Q_PW-1:0]  wr_nxt;

    assign o_room = (r_cnt <= Q_CW'(Q_DEPTH - 2));
    assign pop    = o_tok.valid && o_tok.ready;
    assign wr_nxt = r_wr + Q_PW'(1);

    assign o_tok.valid       = (r_cnt != '0);
    assign o_tok.kind        = r_mem[r_rd].kind;
    assign o_tok.char_value  = r_mem[r_rd].ch;
    assign o_tok.line_number = r_mem[r_rd].line;
    assign o_tok.last_of_run = r_mem[r_rd].last;

    always_comb begin
        n_wr  = r_wr + Q_PW'(i_push.cnt);
        n_rd  = r_rd + Q_PW'(pop);
        n_cnt = r_cnt + Q_CW'(i_push.cnt) - Q_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.e0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_nxt] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: src/json_byte_lexer.sv
// Top level: byte-serial JSON tokenizer with input register and result queue.
//
//  channel  | dir | payload                                        | handshake
//  i_text   | in  | text_byte[7:0]                                 | valid/ready
//  o_tok    | out | kind[3:0] char_value[7:0] line_number[15:0]    | valid/ready
//           |     | last_of_run                                    |
//
// One byte a cycle while the queue has room; path: input register, decode, queue.
// A byte makes zero to two tokens; the queue drains one token a cycle when ready,
// so a run of two-token bytes throttles input to the output rate.
// The decode stage fires when the queue has room for two tokens.
// Synchronous reset: lexer idle, line count one, queue empty.
`timescale 1ns / 1ps

module json_byte_lexer
    import jbl_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jbl_byte_if.sink   i_text,
    jbl_tok_if.source  o_tok
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       room;
    logic       lex_en;
    t_push      push;

    assign lex_en       = r_in_vld && room;
    assign i_text.ready = !r_in_vld || lex_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_text.ready) begin
            r_in_vld <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.ready && i_text.valid) begin
            r_in_byte <= i_text.text_byte;
        end
    end

    jbl_lex #(
        .LINE_BITS (LINE_BITS)
    ) u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (lex_en),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    jbl_res_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_tok   (o_tok)
    );

endmodule
